/* rtl/orientation_incircle_predicate_macros.svh */
// Assertion helpers for the predicate block; aclk and aresetn must be in scope.
`ifndef ORIENTATION_INCIRCLE_PREDICATE_MACROS_SVH
`define ORIENTATION_INCIRCLE_PREDICATE_MACROS_SVH

// same-cycle implication
`define OIP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OIP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/oip_pkg.sv */
package oip_pkg;

    typedef enum logic {
        FUNC_ORIENT   = 1'b0,
        FUNC_INCIRCLE = 1'b1
    } func_t;

    localparam int THR_BITS      = 63;
    localparam int OUT_DATA_BITS = 8;

endpackage

/* rtl/orientation_incircle_predicate.sv */
// Channel   Direction  Handshake                 Payload
// s_        in         s_tvalid / s_tready       tuser: func; tdata: ax ay bx by cx cy tx ty
// m_        out        m_tvalid / m_tready       tdata: above_threshold
// cfg_      in         cfg_valid / cfg_ready     cfg_data: det_threshold
//
// One request per cycle unless an m_tready stall fills the pipe. Nine register stages
// from acceptance to m_tvalid: three for differences, products and sums, three for the
// split wide multiply, three for the final adds, selection and threshold compare.
// aresetn is synchronous, active low; it empties the pipe and sets the threshold to 0.
// A stall on m_tready holds the result; empty stages upstream still fill, and
// s_tready drops only when every stage holds a request.
module orientation_incircle_predicate #(
    parameter int COORD_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic                                 s_tuser,   // [0] func
    input  logic [8*COORD_BITS-1:0]              s_tdata,   // ax, ay, bx, by_coord, cx, cy, tx, ty
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [oip_pkg::OUT_DATA_BITS-1:0]    m_tdata,   // [0] above_threshold, rest zero
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [oip_pkg::THR_BITS-1:0]         cfg_data
);

    import oip_pkg::*;

    localparam int C = COORD_BITS;
    localparam int P = 2 * C + 3;

    logic [THR_BITS-1:0] thr_reg;

    logic                 prep_valid, prep_ready;
    func_t                prep_func;
    logic signed [P-1:0]  prep_usq, prep_vsq, prep_ssq, prep_c0, prep_c1, prep_c2, prep_od;

    logic                 mul_valid, mul_ready;
    func_t                mul_func;
    logic signed [2*P-1:0] mul_t0, mul_t1, mul_t2;
    logic signed [P-1:0]  mul_od;

    logic                 above;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    oip_prep #(
        .COORD_BITS (C)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (func_t'(s_tuser)),
        .in_ax     ($signed(s_tdata[0*C +: C])),
        .in_ay     ($signed(s_tdata[1*C +: C])),
        .in_bx     ($signed(s_tdata[2*C +: C])),
        .in_by     ($signed(s_tdata[3*C +: C])),
        .in_cx     ($signed(s_tdata[4*C +: C])),
        .in_cy     ($signed(s_tdata[5*C +: C])),
        .in_tx     ($signed(s_tdata[6*C +: C])),
        .in_ty     ($signed(s_tdata[7*C +: C])),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_func  (prep_func),
        .out_usq   (prep_usq),
        .out_vsq   (prep_vsq),
        .out_ssq   (prep_ssq),
        .out_c0    (prep_c0),
        .out_c1    (prep_c1),
        .out_c2    (prep_c2),
        .out_od    (prep_od)
    );

    oip_lift_mul #(
        .COORD_BITS (C)
    ) u_lift_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_func   (prep_func),
        .in_usq    (prep_usq),
        .in_vsq    (prep_vsq),
        .in_ssq    (prep_ssq),
        .in_c0     (prep_c0),
        .in_c1     (prep_c1),
        .in_c2     (prep_c2),
        .in_od     (prep_od),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_func  (mul_func),
        .out_t0    (mul_t0),
        .out_t1    (mul_t1),
        .out_t2    (mul_t2),
        .out_od    (mul_od)
    );

    oip_decide #(
        .COORD_BITS (C)
    ) u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_func   (mul_func),
        .in_t0     (mul_t0),
        .in_t1     (mul_t1),
        .in_t2     (mul_t2),
        .in_od     (mul_od),
        .in_thr    (thr_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_above (above)
    );

    assign m_tdata = OUT_DATA_BITS'(above);

endmodule

/* rtl/oip_pipe_ctrl.sv */
module oip_pipe_ctrl #(
    parameter int STAGES = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAGES-1:0] adv
);

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;

    // a stage moves when it is empty or the one after it moves: bubbles close up
    always_comb begin
        adv[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign v_next    = {v_reg[STAGES-2:0], in_valid};
    assign in_ready  = adv[0];
    assign out_valid = v_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < STAGES; i++) begin
                if (adv[i]) begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

endmodule

/* rtl/oip_prep.sv */
module oip_prep #(
    parameter int COORD_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  oip_pkg::func_t                in_func,
    input  logic signed [COORD_BITS-1:0]  in_ax,
    input  logic signed [COORD_BITS-1:0]  in_ay,
    input  logic signed [COORD_BITS-1:0]  in_bx,
    input  logic signed [COORD_BITS-1:0]  in_by,
    input  logic signed [COORD_BITS-1:0]  in_cx,
    input  logic signed [COORD_BITS-1:0]  in_cy,
    input  logic signed [COORD_BITS-1:0]  in_tx,
    input  logic signed [COORD_BITS-1:0]  in_ty,
    output logic                          out_valid,
    input  logic                          out_ready,
    output oip_pkg::func_t                out_func,
    output logic signed [2*COORD_BITS+2:0] out_usq,
    output logic signed [2*COORD_BITS+2:0] out_vsq,
    output logic signed [2*COORD_BITS+2:0] out_ssq,
    output logic signed [2*COORD_BITS+2:0] out_c0,
    output logic signed [2*COORD_BITS+2:0] out_c1,
    output logic signed [2*COORD_BITS+2:0] out_c2,
    output logic signed [2*COORD_BITS+2:0] out_od
);

    import oip_pkg::*;

    localparam int D  = COORD_BITS + 1;
    localparam int Q  = 2 * D;
    localparam int P  = Q + 1;
    localparam int NS = 3;

    logic [NS-1:0] adv;

    // stage 1: differences
    func_t               func1_reg;
    logic signed [D-1:0] ux_reg, uy_reg, vx_reg, vy_reg, sx_reg, sy_reg;
    logic signed [D-1:0] d1_reg, d2_reg, d3_reg, d4_reg;
    // stage 2: products
    func_t               func2_reg;
    logic signed [Q-1:0] uxx_reg, uyy_reg, vxx_reg, vyy_reg, sxx_reg, syy_reg;
    logic signed [Q-1:0] vxsy_reg, vysx_reg, uxsy_reg, uysx_reg, uxvy_reg, uyvx_reg;
    logic signed [Q-1:0] p1_reg, p2_reg;
    // stage 3: sums
    func_t               func3_reg;
    logic signed [P-1:0] usq_reg, vsq_reg, ssq_reg, c0_reg, c1_reg, c2_reg, od_reg;

    oip_pipe_ctrl #(
        .STAGES (NS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .adv       (adv)
    );

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            func1_reg <= in_func;
            ux_reg    <= D'(in_ax) - D'(in_tx);
            uy_reg    <= D'(in_ay) - D'(in_ty);
            vx_reg    <= D'(in_bx) - D'(in_tx);
            vy_reg    <= D'(in_by) - D'(in_ty);
            sx_reg    <= D'(in_cx) - D'(in_tx);
            sy_reg    <= D'(in_cy) - D'(in_ty);
            d1_reg    <= D'(in_ax) - D'(in_bx);
            d2_reg    <= D'(in_ay) - D'(in_cy);
            d3_reg    <= D'(in_ax) - D'(in_cx);
            d4_reg    <= D'(in_ay) - D'(in_by);
        end
        if (adv[1]) begin
            func2_reg <= func1_reg;
            uxx_reg   <= Q'(ux_reg) * Q'(ux_reg);
            uyy_reg   <= Q'(uy_reg) * Q'(uy_reg);
            vxx_reg   <= Q'(vx_reg) * Q'(vx_reg);
            vyy_reg   <= Q'(vy_reg) * Q'(vy_reg);
            sxx_reg   <= Q'(sx_reg) * Q'(sx_reg);
            syy_reg   <= Q'(sy_reg) * Q'(sy_reg);
            vxsy_reg  <= Q'(vx_reg) * Q'(sy_reg);
            vysx_reg  <= Q'(vy_reg) * Q'(sx_reg);
            uxsy_reg  <= Q'(ux_reg) * Q'(sy_reg);
            uysx_reg  <= Q'(uy_reg) * Q'(sx_reg);
            uxvy_reg  <= Q'(ux_reg) * Q'(vy_reg);
            uyvx_reg  <= Q'(uy_reg) * Q'(vx_reg);
            p1_reg    <= Q'(d1_reg) * Q'(d2_reg);
            p2_reg    <= Q'(d3_reg) * Q'(d4_reg);
        end
        if (adv[2]) begin
            func3_reg <= func2_reg;
            usq_reg   <= P'(uxx_reg) + P'(uyy_reg);
            vsq_reg   <= P'(vxx_reg) + P'(vyy_reg);
            ssq_reg   <= P'(sxx_reg) + P'(syy_reg);
            c0_reg    <= P'(vxsy_reg) - P'(vysx_reg);
            c1_reg    <= P'(uxsy_reg) - P'(uysx_reg);
            c2_reg    <= P'(uxvy_reg) - P'(uyvx_reg);
            od_reg    <= P'(p1_reg) - P'(p2_reg);
        end
    end

    assign out_func = func3_reg;
    assign out_usq  = usq_reg;
    assign out_vsq  = vsq_reg;
    assign out_ssq  = ssq_reg;
    assign out_c0   = c0_reg;
    assign out_c1   = c1_reg;
    assign out_c2   = c2_reg;
    assign out_od   = od_reg;

endmodule

/* rtl/oip_lift_mul.sv */
module oip_lift_mul #(
    parameter int COORD_BITS = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  oip_pkg::func_t                  in_func,
    input  logic signed [2*COORD_BITS+2:0]  in_usq,
    input  logic signed [2*COORD_BITS+2:0]  in_vsq,
    input  logic signed [2*COORD_BITS+2:0]  in_ssq,
    input  logic signed [2*COORD_BITS+2:0]  in_c0,
    input  logic signed [2*COORD_BITS+2:0]  in_c1,
    input  logic signed [2*COORD_BITS+2:0]  in_c2,
    input  logic signed [2*COORD_BITS+2:0]  in_od,
    output logic                            out_valid,
    input  logic                            out_ready,
    output oip_pkg::func_t                  out_func,
    output logic signed [4*COORD_BITS+5:0]  out_t0,
    output logic signed [4*COORD_BITS+5:0]  out_t1,
    output logic signed [4*COORD_BITS+5:0]  out_t2,
    output logic signed [2*COORD_BITS+2:0]  out_od
);

    import oip_pkg::*;

    localparam int P     = 2 * COORD_BITS + 3;
    localparam int H     = (P + 1) / 2;   // low limb, unsigned
    localparam int G     = P - H;         // high limb, signed
    localparam int LL_W  = 2 * H;
    localparam int X_W   = P + 1;         // cross partials: (H+1) x G signed
    localparam int HH_W  = 2 * G;
    localparam int MID_W = P + 2;
    localparam int PR_W  = 2 * P;
    localparam int NS    = 3;
    localparam int NM    = 3;

    logic [NS-1:0] adv;

    logic signed [P-1:0] mul_a [NM];
    logic signed [P-1:0] mul_b [NM];

    logic [LL_W-1:0]        ll_reg   [NM];
    logic signed [X_W-1:0]  lh_reg   [NM];
    logic signed [X_W-1:0]  hl_reg   [NM];
    logic signed [HH_W-1:0] hh_reg   [NM];
    logic signed [MID_W-1:0] mid_reg [NM];
    logic signed [PR_W-1:0] cat_reg  [NM];
    logic signed [PR_W-1:0] prod_reg [NM];

    func_t               func_reg [NS];
    logic signed [P-1:0] od_reg   [NS];

    oip_pipe_ctrl #(
        .STAGES (NS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .adv       (adv)
    );

    assign mul_a[0] = in_usq;
    assign mul_b[0] = in_c0;
    assign mul_a[1] = in_vsq;
    assign mul_b[1] = in_c1;
    assign mul_a[2] = in_ssq;
    assign mul_b[2] = in_c2;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            func_reg[0] <= in_func;
            od_reg[0]   <= in_od;
            for (int k = 0; k < NM; k++) begin
                ll_reg[k] <= LL_W'(mul_a[k][H-1:0]) * LL_W'(mul_b[k][H-1:0]);
                lh_reg[k] <= X_W'($signed({1'b0, mul_a[k][H-1:0]}))
                           * X_W'($signed(mul_b[k][P-1:H]));
                hl_reg[k] <= X_W'($signed(mul_a[k][P-1:H]))
                           * X_W'($signed({1'b0, mul_b[k][H-1:0]}));
                hh_reg[k] <= HH_W'($signed(mul_a[k][P-1:H]))
                           * HH_W'($signed(mul_b[k][P-1:H]));
            end
        end
        if (adv[1]) begin
            func_reg[1] <= func_reg[0];
            od_reg[1]   <= od_reg[0];
            for (int k = 0; k < NM; k++) begin
                mid_reg[k] <= MID_W'(lh_reg[k]) + MID_W'(hl_reg[k]);
                // outer partials do not overlap, so they just abut
                cat_reg[k] <= $signed({hh_reg[k], ll_reg[k]});
            end
        end
        if (adv[2]) begin
            func_reg[2] <= func_reg[1];
            od_reg[2]   <= od_reg[1];
            for (int k = 0; k < NM; k++) begin
                prod_reg[k] <= cat_reg[k] + (PR_W'(mid_reg[k]) <<< H);
            end
        end
    end

    assign out_func = func_reg[NS-1];
    assign out_od   = od_reg[NS-1];
    assign out_t0   = prod_reg[0];
    assign out_t1   = prod_reg[1];
    assign out_t2   = prod_reg[2];

endmodule

/* rtl/oip_decide.sv */
module oip_decide #(
    parameter int COORD_BITS = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  oip_pkg::func_t                  in_func,
    input  logic signed [4*COORD_BITS+5:0]  in_t0,
    input  logic signed [4*COORD_BITS+5:0]  in_t1,
    input  logic signed [4*COORD_BITS+5:0]  in_t2,
    input  logic signed [2*COORD_BITS+2:0]  in_od,
    input  logic [oip_pkg::THR_BITS-1:0]    in_thr,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_above
);

    import oip_pkg::*;

    localparam int P    = 2 * COORD_BITS + 3;
    localparam int PR_W = 2 * P;
    localparam int S_W  = PR_W + 1;
    localparam int W    = PR_W + 2;
    localparam int CW   = (W > THR_BITS + 1) ? W : THR_BITS + 1;
    localparam int NS   = 3;

    logic [NS-1:0] adv;

    func_t                 func_reg;
    logic signed [S_W-1:0]  s01_reg;
    logic signed [PR_W-1:0] t2_reg;
    logic signed [P-1:0]    od_reg;
    logic signed [W-1:0]    det_reg;
    logic                   above_reg;

    oip_pipe_ctrl #(
        .STAGES (NS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .adv       (adv)
    );

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            func_reg <= in_func;
            s01_reg  <= S_W'(in_t0) - S_W'(in_t1);
            t2_reg   <= in_t2;
            od_reg   <= in_od;
        end
        if (adv[1]) begin
            det_reg <= (func_reg == FUNC_INCIRCLE) ? W'(s01_reg) + W'(t2_reg) : W'(od_reg);
        end
        if (adv[2]) begin
            // negative det never passes; otherwise an unsigned compare is exact
            above_reg <= !det_reg[W-1] && (CW'(det_reg) > CW'(in_thr));
        end
    end

    assign out_above = above_reg;

endmodule

/* rtl/oip_checker.sv */
`include "orientation_incircle_predicate_macros.svh"

module oip_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [oip_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    import oip_pkg::*;

    // a waiting result must not change under a stall
    `OIP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    // only the flag bit may be set
    `OIP_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[OUT_DATA_BITS-1:1] == '0, "padding bits set")
    // with the output slot free the whole pipe can move
    `OIP_ASSERT_IMP(a_ready_free, !m_tvalid, s_tready, "input blocked with empty output")
    // a draining output never blocks the input
    `OIP_ASSERT_IMP(a_ready_drain, m_tready, s_tready, "input blocked while output drains")

endmodule

bind orientation_incircle_predicate oip_checker u_oip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
